// File: sv/lebc_pkg.sv
// ----------------------------------------------------------------------------
// lebc_pkg
// shared types and constants of the latch edge and bump classifier
// ----------------------------------------------------------------------------
package lebc_pkg;

  localparam int LATCH_W   = 8;
  localparam int CODE_W    = 3;
  localparam int CODES_W   = LATCH_W * CODE_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [CODE_W-1:0] CODE_LOW       = 3'd0;
  localparam logic [CODE_W-1:0] CODE_HIGH      = 3'd1;
  localparam logic [CODE_W-1:0] CODE_RISE_EDGE = 3'd2;
  localparam logic [CODE_W-1:0] CODE_FALL_EDGE = 3'd3;
  localparam logic [CODE_W-1:0] CODE_RISE_BUMP = 3'd4;
  localparam logic [CODE_W-1:0] CODE_FALL_BUMP = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_RISE_EDGE_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_EDGE_MASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_BUMP_MASK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_BUMP_MASK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS   = 3'd4;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  localparam logic [LATCH_W-1:0] SETTLE_RESET = 8'd100;

  typedef struct packed {
    logic [LATCH_W-1:0] rise_edge_mask;
    logic [LATCH_W-1:0] fall_edge_mask;
    logic [LATCH_W-1:0] rise_bump_mask;
    logic [LATCH_W-1:0] fall_bump_mask;
    logic [LATCH_W-1:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic               open;
    logic               close;
    logic               pending_push;
    logic [LATCH_W-1:0] last_levels;
    logic [LATCH_W-1:0] first_sample;
  } win_stat_t;

endpackage

// File: sv/lebc_cfg_regs.sv
// ----------------------------------------------------------------------------
// lebc_cfg_regs
// configuration register file: edge and bump masks, settle window length
// ----------------------------------------------------------------------------
module lebc_cfg_regs
  import lebc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [CFG_IDX_W-1:0] index_i,
  input  logic [LATCH_W-1:0]   wdata_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (index_i)
        REG_RISE_EDGE_MASK: cfg_d.rise_edge_mask = wdata_i;
        REG_FALL_EDGE_MASK: cfg_d.fall_edge_mask = wdata_i;
        REG_RISE_BUMP_MASK: cfg_d.rise_bump_mask = wdata_i;
        REG_FALL_BUMP_MASK: cfg_d.fall_bump_mask = wdata_i;
        REG_SETTLE_TICKS:   cfg_d.settle_ticks   = wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rise_edge_mask <= '0;
      cfg_q.fall_edge_mask <= '0;
      cfg_q.rise_bump_mask <= '0;
      cfg_q.fall_bump_mask <= '0;
      cfg_q.settle_ticks   <= SETTLE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/lebc_window.sv
// ----------------------------------------------------------------------------
// lebc_window
// settle window state: snapshot, last levels, tick counter, close decision
// ----------------------------------------------------------------------------
module lebc_window
  import lebc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               mode_i,
  input  logic [LATCH_W-1:0] levels_i,
  input  logic               force_i,
  input  logic [LATCH_W-1:0] settle_ticks_i,
  output win_stat_t          stat_o
);

  logic               open_q, open_d;
  logic               pend_q, pend_d;
  logic [LATCH_W-1:0] last_q, last_d;
  logic [LATCH_W-1:0] first_q, first_d;
  logic [LATCH_W-1:0] cnt_q, cnt_d;
  logic [LATCH_W-1:0] cnt_inc;
  logic               close;

  assign cnt_inc = cnt_q + 8'd1;
  assign close   = open_q && (mode_i == MODE_TICK)
                   && ((levels_i == last_q) || !(cnt_inc < settle_ticks_i));

  always_comb begin
    open_d  = open_q;
    pend_d  = pend_q;
    last_d  = last_q;
    first_d = first_q;
    cnt_d   = cnt_q;
    if (step_i) begin
      if (mode_i == MODE_START) begin
        if (!open_q) begin
          first_d = levels_i;
          pend_d  = force_i;
          cnt_d   = '0;
          open_d  = 1'b1;
        end
      end else if (open_q) begin
        if (close) begin
          last_d = levels_i;
          open_d = 1'b0;
          cnt_d  = '0;
          pend_d = 1'b0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      pend_q  <= 1'b0;
      last_q  <= '0;
      first_q <= '0;
      cnt_q   <= '0;
    end else begin
      open_q  <= open_d;
      pend_q  <= pend_d;
      last_q  <= last_d;
      first_q <= first_d;
      cnt_q   <= cnt_d;
    end
  end

  assign stat_o.open         = open_q;
  assign stat_o.close        = close;
  assign stat_o.pending_push = pend_q;
  assign stat_o.last_levels  = last_q;
  assign stat_o.first_sample = first_q;

endmodule

// File: sv/lebc_classify.sv
// ----------------------------------------------------------------------------
// lebc_classify
// per-latch priority classification into bump, edge or level codes
// ----------------------------------------------------------------------------
module lebc_classify
  import lebc_pkg::*;
(
  input  cfg_t               cfg_i,
  input  win_stat_t          stat_i,
  input  logic [LATCH_W-1:0] levels_i,
  output logic [CODES_W-1:0] codes_o,
  output logic               push_o
);

  logic [CODE_W-1:0] code [LATCH_W];

  always_comb begin
    for (int i = 0; i < LATCH_W; i++) begin
      logic last_b, first_b, post_b;
      last_b  = stat_i.last_levels[i];
      first_b = stat_i.first_sample[i];
      post_b  = levels_i[i];
      if (first_b != post_b && !last_b && cfg_i.rise_bump_mask[i]) begin
        code[i] = CODE_RISE_BUMP;
      end else if (first_b != post_b && last_b && cfg_i.fall_bump_mask[i]) begin
        code[i] = CODE_FALL_BUMP;
      end else if (last_b != first_b && !last_b && cfg_i.rise_edge_mask[i]) begin
        code[i] = CODE_RISE_EDGE;
      end else if (last_b != first_b && last_b && cfg_i.fall_edge_mask[i]) begin
        code[i] = CODE_FALL_EDGE;
      end else begin
        code[i] = post_b ? CODE_HIGH : CODE_LOW;
      end
    end
  end

  always_comb begin
    push_o = stat_i.pending_push;
    for (int i = 0; i < LATCH_W; i++) begin
      codes_o[i*CODE_W +: CODE_W] = code[i];
      if (code[i] > CODE_HIGH) begin
        push_o = 1'b1;
      end
    end
  end

endmodule

// File: sv/latch_edge_bump_classifier.sv
// throughput: one word per cycle unless a held result word stalls the input; an input register
// and a result register split the work, window state is updated as each word leaves the input register
// only a tick word that closes the settle window yields a result word
// reset: asynchronous, active low; clears window state, masks to zero and
// the settle length to 100
// ----------------------------------------------------------------------------
// latch_edge_bump_classifier
// pin-change settle window with per-latch edge and bump classification
// ----------------------------------------------------------------------------
module latch_edge_bump_classifier
  import lebc_pkg::*;
#(
  parameter int NUM_LATCHES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 mode_i,
  input  logic [LATCH_W-1:0]   pin_levels_i,
  input  logic                 force_push_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CODES_W-1:0]   event_codes_o,
  output logic                 push_entry_o,
  output logic [LATCH_W-1:0]   new_levels_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LATCH_W-1:0]   cfg_wdata_i
);

  cfg_t               cfg;
  win_stat_t          stat;
  logic [LATCH_W-1:0] lvl_mask;

  logic               s1_valid_q, s1_valid_d;
  logic               s1_mode_q;
  logic [LATCH_W-1:0] s1_levels_q;
  logic               s1_force_q;
  logic               s1_load, s1_move, s1_step;

  logic               out_valid_q, out_valid_d;
  logic [CODES_W-1:0] codes_q;
  logic               push_q;
  logic [LATCH_W-1:0] new_levels_q;
  logic [CODES_W-1:0] codes;
  logic               push;
  logic               out_free, out_load;

  always_comb begin
    for (int i = 0; i < LATCH_W; i++) begin
      lvl_mask[i] = (i < NUM_LATCHES);
    end
  end

  lebc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign s1_load    = in_valid_i && !in_stall_o;
  assign s1_step    = s1_valid_q && s1_move;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_mode_q   <= mode_i;
      s1_levels_q <= pin_levels_i & lvl_mask;
      s1_force_q  <= force_push_i;
    end
  end

  lebc_window u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (s1_step),
    .mode_i         (s1_mode_q),
    .levels_i       (s1_levels_q),
    .force_i        (s1_force_q),
    .settle_ticks_i (cfg.settle_ticks),
    .stat_o         (stat)
  );

  lebc_classify u_classify (
    .cfg_i    (cfg),
    .stat_i   (stat),
    .levels_i (s1_levels_q),
    .codes_o  (codes),
    .push_o   (push)
  );

  assign out_load = s1_step && stat.close;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      codes_q      <= codes;
      push_q       <= push;
      new_levels_q <= s1_levels_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_codes_o = codes_q;
  assign push_entry_o  = push_q;
  assign new_levels_o  = new_levels_q;

`ifndef SYNTHESIS
  a_result_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_mode_q == MODE_TICK && stat.open))
    else $error("result word without a closing tick");

  a_window_shut: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> !stat.open)
    else $error("settle window still open after close");

  a_unused_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((new_levels_q & ~lvl_mask) == '0))
    else $error("levels of absent latches reported");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with room in the pipeline");
`endif

endmodule
